/* hw/rtl/spq_pkg.sv */
// Shared types and constants for the stable priority queue.
// Used by spq_cell, stable_priority_queue and the testbench; depends on nothing else.
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int PRIO_BITS = 8;
  localparam int ID_BITS   = 16;

  // Field widths of the stream payloads.
  localparam int MODE_W     = 2;
  localparam int PRIO_W     = 8;
  localparam int ID_W       = 16;
  localparam int STATUS_W   = 2;
  localparam int TDATA_W    = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef struct packed {
    logic                 vld;
    logic [PRIO_BITS-1:0] prio;
    logic [ID_BITS-1:0]   id;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    op_t                  op;
    logic                 pop;
    logic [PRIO_BITS-1:0] prio;
    logic [ID_BITS-1:0]   new_id;
    logic [ID_BITS-1:0]   tid;
  } cmd_t;

endpackage

/* hw/rtl/spq_cell.sv */
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell (
  input  logic           clk,
  input  logic           rst,
  input  spq_pkg::cmd_t  cmd,
  input  logic           head,
  input  spq_pkg::entry_t left_entry,
  input  logic           left_ge,
  input  spq_pkg::entry_t right_entry,
  input  logic           hit_in,
  input  spq_pkg::entry_t sel_in,
  output spq_pkg::entry_t entry,
  output logic           ge,
  output logic           hit_out,
  output spq_pkg::entry_t sel_out
);

  logic                          vld;
  logic                          vld_next;
  logic [spq_pkg::PRIO_BITS-1:0] prio;
  logic [spq_pkg::PRIO_BITS-1:0] prio_next;
  logic [spq_pkg::ID_BITS-1:0]   id;
  logic [spq_pkg::ID_BITS-1:0]   id_next;
  logic                          match;

  assign entry = '{vld: vld, prio: prio, id: id};

  // The chain is sorted, so ge is true on a prefix of the cells.
  assign ge    = vld && (prio >= cmd.prio);
  assign match = vld && (cmd.pop ? head : (id == cmd.tid));

  // Only the first match from the head is removed; later cells see hit_in.
  assign hit_out = hit_in || match;
  assign sel_out = hit_in ? sel_in : (match ? entry : '0);

  always_comb begin
    vld_next  = vld;
    prio_next = prio;
    id_next   = id;
    unique case (cmd.op)
      spq_pkg::OP_INSERT: begin
        if (!ge) begin
          if (head || left_ge) begin
            vld_next  = 1'b1;
            prio_next = cmd.prio;
            id_next   = cmd.new_id;
          end else begin
            vld_next  = left_entry.vld;
            prio_next = left_entry.prio;
            id_next   = left_entry.id;
          end
        end
      end
      spq_pkg::OP_DELETE: begin
        if (hit_out) begin
          vld_next  = right_entry.vld;
          prio_next = right_entry.prio;
          id_next   = right_entry.id;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    prio <= prio_next;
    id   <= id_next;
  end

endmodule

/* hw/rtl/stable_priority_queue.sv */
// Stable priority queue built as a chain of sorted cells.
// A request is answered in the result register, which is loaded at the edge that takes it.
// Throughput: one request per cycle while results are taken; the cycle is set by
// the match flag and compare that ripple through all cells of the chain.
// Reset: synchronous; empties every cell and sets the next id to 1.
// Depends on spq_pkg and spq_cell.
module stable_priority_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [1:0] mode, [9:2] priority_req, [25:10] target_id, [31:26] zero
  input  logic [spq_pkg::TDATA_W-1:0] s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [1:0] status, [17:2] out_id, [25:18] out_priority, [31:26] zero
  output logic [spq_pkg::TDATA_W-1:0] m_tdata
);

  localparam int LAST = spq_pkg::DEPTH - 1;

  spq_pkg::entry_t entry_w [spq_pkg::DEPTH];
  spq_pkg::entry_t sel_w   [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0] ge_w;
  logic [spq_pkg::DEPTH-1:0] hit_w;
  logic [spq_pkg::DEPTH-1:0] vld_vec;

  spq_pkg::mode_t                mode;
  logic [spq_pkg::PRIO_BITS-1:0] req_prio;
  logic [spq_pkg::ID_BITS-1:0]   req_tid;
  logic                          s_acc;
  logic                          full;
  spq_pkg::cmd_t                 cmd;

  logic [spq_pkg::ID_BITS-1:0]   next_id;
  logic [spq_pkg::ID_BITS-1:0]   next_id_next;
  logic [spq_pkg::ID_BITS-1:0]   id_inc;

  logic                          m_valid;
  spq_pkg::status_t              res_status;
  logic [spq_pkg::ID_W-1:0]      res_id;
  logic [spq_pkg::PRIO_W-1:0]    res_prio;
  spq_pkg::status_t              out_status;
  logic [spq_pkg::ID_W-1:0]      out_id;
  logic [spq_pkg::PRIO_W-1:0]    out_prio;

  assign mode     = spq_pkg::mode_t'(s_tdata[1:0]);
  assign req_prio = spq_pkg::PRIO_BITS'(s_tdata[9:2]);
  assign req_tid  = spq_pkg::ID_BITS'(s_tdata[25:10]);

  assign s_tready = !m_valid || m_tready;
  assign s_acc    = s_tvalid && s_tready;
  assign full     = entry_w[LAST].vld;

  always_comb begin
    cmd.op     = spq_pkg::OP_HOLD;
    cmd.pop    = (mode == spq_pkg::MODE_POP);
    cmd.prio   = req_prio;
    cmd.new_id = next_id;
    cmd.tid    = req_tid;
    if (s_acc) begin
      unique case (mode)
        spq_pkg::MODE_INSERT: cmd.op = full ? spq_pkg::OP_HOLD : spq_pkg::OP_INSERT;
        spq_pkg::MODE_POP:    cmd.op = spq_pkg::OP_DELETE;
        spq_pkg::MODE_REMOVE: cmd.op = spq_pkg::OP_DELETE;
        spq_pkg::MODE_NOP:    cmd.op = spq_pkg::OP_HOLD;
      endcase
    end
  end

  for (genvar k = 0; k < spq_pkg::DEPTH; k++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    spq_pkg::entry_t sel_in;
    logic            left_ge;
    logic            hit_in;

    if (k == 0) begin : g_head
      assign left_entry = '0;
      assign left_ge    = 1'b0;
      assign hit_in     = 1'b0;
      assign sel_in     = '0;
    end else begin : g_body
      assign left_entry = entry_w[k-1];
      assign left_ge    = ge_w[k-1];
      assign hit_in     = hit_w[k-1];
      assign sel_in     = sel_w[k-1];
    end

    if (k == LAST) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entry_w[k+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .head       (k == 0),
      .left_entry (left_entry),
      .left_ge    (left_ge),
      .right_entry(right_entry),
      .hit_in     (hit_in),
      .sel_in     (sel_in),
      .entry      (entry_w[k]),
      .ge         (ge_w[k]),
      .hit_out    (hit_w[k]),
      .sel_out    (sel_w[k])
    );

    assign vld_vec[k] = entry_w[k].vld;
  end

  // Ids count up and skip zero.
  assign id_inc = next_id + 1'b1;
  always_comb begin
    next_id_next = next_id;
    if (cmd.op == spq_pkg::OP_INSERT) begin
      next_id_next = (id_inc == '0) ? spq_pkg::ID_BITS'(1) : id_inc;
    end
  end

  always_comb begin
    res_status = spq_pkg::STATUS_OK;
    res_id     = '0;
    res_prio   = '0;
    unique case (mode)
      spq_pkg::MODE_INSERT: begin
        if (full) begin
          res_status = spq_pkg::STATUS_FULL;
        end else begin
          res_id   = spq_pkg::ID_W'(next_id);
          res_prio = spq_pkg::PRIO_W'(req_prio);
        end
      end
      spq_pkg::MODE_POP, spq_pkg::MODE_REMOVE: begin
        if (hit_w[LAST]) begin
          res_id   = spq_pkg::ID_W'(sel_w[LAST].id);
          res_prio = spq_pkg::PRIO_W'(sel_w[LAST].prio);
        end else begin
          res_status = spq_pkg::STATUS_MISS;
        end
      end
      spq_pkg::MODE_NOP: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_id <= spq_pkg::ID_BITS'(1);
      m_valid <= 1'b0;
    end else begin
      next_id <= next_id_next;
      if (s_acc) begin
        m_valid <= 1'b1;
      end else if (m_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      out_status <= res_status;
      out_id     <= res_id;
      out_prio   <= res_prio;
    end
  end

  assign m_tvalid = m_valid;
  assign m_tdata  = {6'd0, out_prio, out_id, out_status};

  // Occupied cells always form a run starting at the head.
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    ((vld_vec >> 1) & ~vld_vec) == '0)
    else $error("occupied cells are not contiguous from the head");

  // A successful insert grows the queue by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == spq_pkg::OP_INSERT) |=>
      ($countones(vld_vec) == $past($countones(vld_vec)) + 1))
    else $error("insert did not add exactly one entry");

  // A found delete shrinks the queue by exactly one entry.
  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == spq_pkg::OP_DELETE && hit_w[LAST]) |=>
      ($countones(vld_vec) + 1 == $past($countones(vld_vec))))
    else $error("delete did not remove exactly one entry");

  // The id counter never holds zero.
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_id != '0)
    else $error("next id reached zero");

endmodule

/* tb/tb_stable_priority_queue.sv */
`timescale 1ns / 100ps
// Self-checking testbench for stable_priority_queue: directed and random requests,
// with results checked against a behavioral copy of the sorted queue.
// Depends on spq_pkg and the stable_priority_queue RTL.
module tb_stable_priority_queue;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int RANDOM_REQUESTS = 780;
  localparam int PLAN_ROWS = 22;

  typedef struct packed {
    spq_pkg::status_t           status;
    logic [spq_pkg::ID_W-1:0]   id;
    logic [spq_pkg::PRIO_W-1:0] prio;
  } answer_t;

  typedef struct {
    spq_pkg::mode_t             mode;
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::ID_W-1:0]   tid;
    bit                         typed;
    answer_t                    want;
  } plan_row_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [spq_pkg::TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [spq_pkg::TDATA_W-1:0] m_tdata;

  stable_priority_queue i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Behavioral copy of the queue, slot 0 is the head.
  logic [spq_pkg::PRIO_BITS-1:0] held_prio [spq_pkg::DEPTH];
  logic [spq_pkg::ID_BITS-1:0]   held_id [spq_pkg::DEPTH];
  int                            held = 0;
  logic [spq_pkg::ID_BITS-1:0]   id_next = spq_pkg::ID_BITS'(1);

  answer_t answers [$];
  int      mismatches = 0;
  bit      idle_on = 1'b1;
  bit      row_typed = 1'b0;
  answer_t row_want = '0;
  answer_t want;
  answer_t got;

  function automatic void drop_entry(int pos);
    for (int k = pos; k + 1 < held; k++) begin
      held_prio[k] = held_prio[k + 1];
      held_id[k] = held_id[k + 1];
    end
    held--;
  endfunction

  function automatic answer_t serve_request(spq_pkg::mode_t mode,
                                            logic [spq_pkg::PRIO_W-1:0] prio,
                                            logic [spq_pkg::ID_W-1:0] tid);
    answer_t r;
    int pos;
    r = '{status: spq_pkg::STATUS_OK, id: '0, prio: '0};
    unique case (mode)
      spq_pkg::MODE_INSERT: begin
        if (held >= spq_pkg::DEPTH) begin
          r.status = spq_pkg::STATUS_FULL;
        end else begin
          // The new entry goes behind every entry of equal or higher priority.
          pos = 0;
          while (pos < held && held_prio[pos] >= prio) pos++;
          for (int k = held; k > pos; k--) begin
            held_prio[k] = held_prio[k - 1];
            held_id[k] = held_id[k - 1];
          end
          held_prio[pos] = prio;
          held_id[pos] = id_next;
          held++;
          r = '{status: spq_pkg::STATUS_OK, id: id_next, prio: prio};
          id_next = id_next + 1'b1;
          if (id_next == '0) id_next = spq_pkg::ID_BITS'(1);
        end
      end
      spq_pkg::MODE_POP: begin
        if (held == 0) begin
          r.status = spq_pkg::STATUS_MISS;
        end else begin
          r = '{status: spq_pkg::STATUS_OK, id: held_id[0], prio: held_prio[0]};
          drop_entry(0);
        end
      end
      spq_pkg::MODE_REMOVE: begin
        r.status = spq_pkg::STATUS_MISS;
        for (pos = 0; pos < held; pos++) begin
          if (held_id[pos] == tid) break;
        end
        if (pos < held) begin
          r = '{status: spq_pkg::STATUS_OK, id: held_id[pos], prio: held_prio[pos]};
          drop_entry(pos);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Results are checked before the request of the same edge is predicted; since results
  // are registered, a result can never belong to the request taken at its edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{status: spq_pkg::status_t'(m_tdata[1:0]), id: m_tdata[17:2],
                prio: m_tdata[25:18]};
        if (answers.size() == 0) begin
          $error("unexpected result: status %0d, out_id %0d, out_priority %0d",
                 got.status, got.id, got.prio);
          mismatches++;
        end else begin
          want = answers.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.id != want.id) begin
            $error("out_id: expected %0d, got %0d", want.id, got.id);
            mismatches++;
          end
          if (got.prio != want.prio) begin
            $error("out_priority: expected %0d, got %0d", want.prio, got.prio);
            mismatches++;
          end
          if (m_tdata[31:26] != '0) begin
            $error("padding: expected 0, got %0d", m_tdata[31:26]);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = serve_request(spq_pkg::mode_t'(s_tdata[1:0]), s_tdata[9:2],
                             s_tdata[25:10]);
        answers.push_back(row_typed ? row_want : want);
      end
    end
  end

  // Result side: a random stall before each result when idling is on.
  initial begin
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic issue_request(input spq_pkg::mode_t mode,
                               input logic [spq_pkg::PRIO_W-1:0] prio,
                               input logic [spq_pkg::ID_W-1:0] tid, input bit typed,
                               input answer_t typed_want);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    row_typed = typed;
    row_want = typed_want;
    s_tdata <= {6'd0, tid, prio, mode};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    plan_row_t plan [PLAN_ROWS];
    mix_t mix;
    spq_pkg::mode_t mode;
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::ID_W-1:0] tid;
    int sent;
    int roll;
    int ins_share;
    int seg_len;

    plan = '{
      '{spq_pkg::MODE_POP,    8'h00, 16'h0000, 1'b1, '{spq_pkg::STATUS_MISS, 16'd0, 8'd0}},
      '{spq_pkg::MODE_REMOVE, 8'h00, 16'h0000, 1'b1, '{spq_pkg::STATUS_MISS, 16'd0, 8'd0}},
      '{spq_pkg::MODE_REMOVE, 8'hFF, 16'hFFFF, 1'b1, '{spq_pkg::STATUS_MISS, 16'd0, 8'd0}},
      '{spq_pkg::MODE_NOP,    8'hFF, 16'hFFFF, 1'b1, '{spq_pkg::STATUS_OK, 16'd0, 8'd0}},
      '{spq_pkg::MODE_INSERT, 8'h00, 16'hFFFF, 1'b1, '{spq_pkg::STATUS_OK, 16'd1, 8'h00}},
      '{spq_pkg::MODE_INSERT, 8'hFF, 16'h0000, 1'b1, '{spq_pkg::STATUS_OK, 16'd2, 8'hFF}},
      '{spq_pkg::MODE_INSERT, 8'h80, 16'h0000, 1'b1, '{spq_pkg::STATUS_OK, 16'd3, 8'h80}},
      '{spq_pkg::MODE_INSERT, 8'h80, 16'h0000, 1'b1, '{spq_pkg::STATUS_OK, 16'd4, 8'h80}},
      '{spq_pkg::MODE_INSERT, 8'hFF, 16'h0000, 1'b1, '{spq_pkg::STATUS_OK, 16'd5, 8'hFF}},
      '{spq_pkg::MODE_POP,    8'h00, 16'h0000, 1'b0, '0},
      '{spq_pkg::MODE_POP,    8'h00, 16'h0000, 1'b0, '0},
      '{spq_pkg::MODE_REMOVE, 8'h00, 16'h0004, 1'b0, '0},
      '{spq_pkg::MODE_REMOVE, 8'h00, 16'h0004, 1'b0, '0},
      '{spq_pkg::MODE_INSERT, 8'h01, 16'hAAAA, 1'b0, '0},
      '{spq_pkg::MODE_INSERT, 8'hAA, 16'h5555, 1'b0, '0},
      '{spq_pkg::MODE_INSERT, 8'h55, 16'h0000, 1'b0, '0},
      '{spq_pkg::MODE_REMOVE, 8'h00, 16'h0006, 1'b0, '0},
      '{spq_pkg::MODE_POP,    8'h00, 16'h0000, 1'b0, '0},
      '{spq_pkg::MODE_NOP,    8'h00, 16'h0000, 1'b1, '{spq_pkg::STATUS_OK, 16'd0, 8'd0}},
      '{spq_pkg::MODE_POP,    8'h00, 16'h0000, 1'b0, '0},
      '{spq_pkg::MODE_REMOVE, 8'h00, 16'h0008, 1'b0, '0},
      '{spq_pkg::MODE_REMOVE, 8'h00, 16'h0002, 1'b0, '0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      issue_request(plan[i].mode, plan[i].prio, plan[i].tid, plan[i].typed, plan[i].want);
    end

    // Fill past full, then drain past empty.
    while (held < spq_pkg::DEPTH) begin
      issue_request(spq_pkg::MODE_INSERT, 8'($urandom_range(0, 3) * 85), 16'h0000,
                    1'b0, '0);
    end
    repeat (2) begin
      issue_request(spq_pkg::MODE_INSERT, 8'($urandom_range(0, 255)), 16'h0000, 1'b0, '0);
    end
    while (held > 0) issue_request(spq_pkg::MODE_POP, 8'h00, 16'h0000, 1'b0, '0);
    issue_request(spq_pkg::MODE_POP, 8'h00, 16'h0000, 1'b0, '0);

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      idle_on = ($urandom_range(0, 4) != 0);
      mix = mix_t'($urandom_range(0, 2));
      ins_share = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 20 : 45;
      seg_len = $urandom_range(8, 40);
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_share) mode = spq_pkg::MODE_INSERT;
        else if (roll < ins_share + (100 - ins_share) / 2) mode = spq_pkg::MODE_POP;
        else if (roll < 97) mode = spq_pkg::MODE_REMOVE;
        else mode = spq_pkg::MODE_NOP;
        // A few priority levels give plenty of ties; the rest spans the range.
        if ($urandom_range(0, 1) == 0) prio = 8'($urandom_range(0, 3) * 85);
        else prio = 8'($urandom_range(0, 255));
        tid = 16'($urandom_range(0, 65535));
        if (mode == spq_pkg::MODE_REMOVE && held > 0 && $urandom_range(0, 3) != 0) begin
          tid = held_id[$urandom_range(0, held - 1)];
        end
        issue_request(mode, prio, tid, 1'b0, '0);
        sent++;
      end
    end

    s_tvalid <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("stable_priority_queue verification clean");
    end else begin
      $display("stable_priority_queue verification failed");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("stable_priority_queue verification failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/stable_priority_queue.sv
tb/tb_stable_priority_queue.sv
